FILE: rtl/cpsf_pkg.sv
// Shared types, codes and helpers for the column predicate scan filter.
// No dependencies; every other file of the block imports this package.
package cpsf_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int KEY_WIDTH           = 64;
   localparam int CSR_DATA_WIDTH      = 64;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int MATCH_COUNT_WIDTH   = 32;
   localparam int QUEUE_DEPTH         = 2;
   localparam int ELEM_BITS_WIDTH     = 7;

   // main operator codes
   localparam logic [2:0] OP_EQ = 3'd0;
   localparam logic [2:0] OP_NE = 3'd1;
   localparam logic [2:0] OP_LT = 3'd2;
   localparam logic [2:0] OP_LE = 3'd3;
   localparam logic [2:0] OP_GT = 3'd4;
   localparam logic [2:0] OP_GE = 3'd5;

   // fused upper bound codes
   localparam logic [1:0] UPPER_NONE = 2'd0;
   localparam logic [1:0] UPPER_LT   = 2'd1;
   localparam logic [1:0] UPPER_LE   = 2'd2;

   // bitmap modes
   localparam logic [1:0] MODE_COUNT = 2'd0;
   localparam logic [1:0] MODE_SET   = 2'd1;
   localparam logic [1:0] MODE_AND   = 2'd2;

   // element size codes
   localparam logic [1:0] SIZE_1B = 2'd0;
   localparam logic [1:0] SIZE_2B = 2'd1;
   localparam logic [1:0] SIZE_4B = 2'd2;
   localparam logic [1:0] SIZE_8B = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMPARE_OP       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMPARE_CONSTANT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_OP         = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_CONSTANT   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BITMAP_MODE      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIZE_CODE        = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELEMENT_SIGNED   = 3'd6;

   typedef struct packed {
      logic [2:0]                compare_op;
      logic [CSR_DATA_WIDTH-1:0] compare_constant;
      logic [1:0]                upper_op;
      logic [CSR_DATA_WIDTH-1:0] upper_constant;
      logic [1:0]                bitmap_mode;
      logic [1:0]                size_code;
      logic                      element_signed;
   } cpsf_cfg_type;

   typedef struct packed {
      logic match_bit;
      logic last_row;
   } cpsf_entry_type;

   typedef struct packed {
      logic           valid;
      cpsf_entry_type entry;
   } cpsf_push_type;

   // Map raw bits to a key whose unsigned order is the element order.
   function automatic logic [KEY_WIDTH-1:0] order_key(
      input logic [KEY_WIDTH-1:0]       raw,
      input logic [ELEM_BITS_WIDTH-1:0] bits,
      input logic                       sgn
   );
      logic [KEY_WIDTH-1:0] mask;
      logic [KEY_WIDTH-1:0] v;
      logic                 sbit;
      mask = ~({KEY_WIDTH{1'b1}} << bits);
      v    = raw & mask;
      sbit = v[6'(bits - 7'd1)];
      if (sgn) begin
         if (sbit) begin
            v = v | ~mask;
         end
         v[KEY_WIDTH-1] = ~v[KEY_WIDTH-1];
      end
      return v;
   endfunction

endpackage

FILE: rtl/column_predicate_scan_filter.sv
// Column predicate scan filter: sustains one request per clock cycle while the result side does not stall.
// A result passes through the front key register, then the two-entry queue,
// then the result register; the queue lets the front keep accepting while
// the result side stalls.
// Reset (synchronous, active high) empties all stages, clears the running
// count and restores the registers: size code 3, signed, all others zero.
module column_predicate_scan_filter #(
   parameter int VALUE_WIDTH = cpsf_pkg::VALUE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = cpsf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cpsf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [cpsf_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [VALUE_WIDTH-1:0]                 req_column_value,
   input  logic                                   req_prior_bit,
   input  logic                                   req_last_row,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_match_bit,
   output logic [cpsf_pkg::MATCH_COUNT_WIDTH-1:0] rsp_match_count,
   output logic                                   rsp_count_final
);
   import cpsf_pkg::*;

   cpsf_cfg_type   cfg_ff, cfg_in;
   cpsf_push_type  push;
   cpsf_entry_type head;
   logic           queue_full;
   logic           queue_empty;
   logic           pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COMPARE_OP:       cfg_in.compare_op       = csr_wdata[2:0];
            CSR_COMPARE_CONSTANT: cfg_in.compare_constant = csr_wdata;
            CSR_UPPER_OP:         cfg_in.upper_op         = csr_wdata[1:0];
            CSR_UPPER_CONSTANT:   cfg_in.upper_constant   = csr_wdata;
            CSR_BITMAP_MODE:      cfg_in.bitmap_mode      = csr_wdata[1:0];
            CSR_SIZE_CODE:        cfg_in.size_code        = csr_wdata[1:0];
            CSR_ELEMENT_SIGNED:   cfg_in.element_signed   = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.compare_op       <= OP_EQ;
         cfg_ff.compare_constant <= '0;
         cfg_ff.upper_op         <= UPPER_NONE;
         cfg_ff.upper_constant   <= '0;
         cfg_ff.bitmap_mode      <= MODE_COUNT;
         cfg_ff.size_code        <= SIZE_8B;
         cfg_ff.element_signed   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpsf_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_column_value (req_column_value),
      .req_prior_bit    (req_prior_bit),
      .req_last_row     (req_last_row),
      .queue_full       (queue_full),
      .push             (push)
   );

   cpsf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .empty (queue_empty),
      .head  (head)
   );

   cpsf_back #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (queue_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_bit   (rsp_match_bit),
      .rsp_match_count (rsp_match_count),
      .rsp_count_final (rsp_count_final)
   );

   // an accepted request occupies the front stage on the next cycle
   a_front_loaded: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (push.valid || req_stall))
      else $error("accepted request did not reach the front stage");

   // a matching row never reports a zero count while the count fits the port
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_match_bit) |-> ((COUNT_WIDTH > MATCH_COUNT_WIDTH) ||
         (rsp_match_count != '0)))
      else $error("match reported with zero count");

   // reset leaves every stage empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall && queue_empty))
      else $error("stages not empty after reset");

endmodule

FILE: rtl/cpsf_front.sv
// Front stage: takes requests, forms the order key and evaluates the predicate.
// Depends on cpsf_pkg; pushes one entry per request into cpsf_queue.
module cpsf_front #(
   parameter int VALUE_WIDTH = cpsf_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cpsf_pkg::cpsf_cfg_type cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_column_value,
   input  logic                   req_prior_bit,
   input  logic                   req_last_row,
   input  logic                   queue_full,
   output cpsf_pkg::cpsf_push_type push
);
   import cpsf_pkg::*;

   localparam logic [ELEM_BITS_WIDTH-1:0] VW = ELEM_BITS_WIDTH'(VALUE_WIDTH);

   logic                       valid_ff, valid_in;
   logic [KEY_WIDTH-1:0]       key_ff, key_in;
   logic                       prior_ff, prior_in;
   logic                       last_ff, last_in;
   logic [ELEM_BITS_WIDTH-1:0] nominal_bits;
   logic [ELEM_BITS_WIDTH-1:0] elem_bits;
   logic [KEY_WIDTH-1:0]       c_key;
   logic [KEY_WIDTH-1:0]       u_key;
   logic                       accept;
   logic                       advance;
   logic                       eq_c, lt_c, lt_u, eq_u;
   logic                       pred_main;
   logic                       pred;

   assign nominal_bits = ELEM_BITS_WIDTH'(8) << cfg.size_code;
   assign elem_bits    = (nominal_bits > VW) ? VW : nominal_bits;

   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign advance   = valid_ff && !queue_full;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      prior_in = prior_ff;
      last_in  = last_ff;
      if (accept) begin
         valid_in = 1'b1;
         key_in   = order_key(KEY_WIDTH'(req_column_value), elem_bits, cfg.element_signed);
         prior_in = req_prior_bit;
         last_in  = req_last_row;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      prior_ff <= prior_in;
      last_ff  <= last_in;
   end

   assign c_key = order_key(cfg.compare_constant, elem_bits, cfg.element_signed);
   assign u_key = order_key(cfg.upper_constant, elem_bits, cfg.element_signed);

   assign eq_c = (key_ff == c_key);
   assign lt_c = (key_ff < c_key);
   assign eq_u = (key_ff == u_key);
   assign lt_u = (key_ff < u_key);

   always_comb begin
      unique case (cfg.compare_op)
         OP_EQ:   pred_main = eq_c;
         OP_NE:   pred_main = !eq_c;
         OP_LT:   pred_main = lt_c;
         OP_LE:   pred_main = lt_c || eq_c;
         OP_GT:   pred_main = !(lt_c || eq_c);
         OP_GE:   pred_main = !lt_c;
         default: pred_main = 1'b0;
      endcase
   end

   always_comb begin
      unique case (cfg.upper_op)
         UPPER_LT: pred = pred_main && lt_u;
         UPPER_LE: pred = pred_main && (lt_u || eq_u);
         default:  pred = pred_main;
      endcase
   end

   always_comb begin
      push.valid           = advance;
      push.entry.match_bit = (cfg.bitmap_mode == MODE_AND) ? (pred && prior_ff) : pred;
      push.entry.last_row  = last_ff;
   end

endmodule

FILE: rtl/cpsf_queue.sv
// Short queue of predicate results between the front and back stages.
// Depends on cpsf_pkg for the entry types and depth.
module cpsf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  cpsf_pkg::cpsf_push_type  push,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output cpsf_pkg::cpsf_entry_type head
);
   import cpsf_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_SLOT = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(QUEUE_DEPTH);

   cpsf_entry_type       slots_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

FILE: rtl/cpsf_back.sv
// Back stage: keeps the saturating match count and holds the result register.
// Depends on cpsf_pkg; drains entries from cpsf_queue.
module cpsf_back #(
   parameter int COUNT_WIDTH = cpsf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   empty,
   input  cpsf_pkg::cpsf_entry_type               head,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_match_bit,
   output logic [cpsf_pkg::MATCH_COUNT_WIDTH-1:0] rsp_match_count,
   output logic                                   rsp_count_final
);
   import cpsf_pkg::*;

   logic [COUNT_WIDTH-1:0]       running_ff, running_in;
   logic [COUNT_WIDTH-1:0]       updated;
   logic [KEY_WIDTH-1:0]         updated_wide;
   logic                         valid_ff, valid_in;
   logic                         bit_ff, bit_in;
   logic [MATCH_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         final_ff, final_in;

   assign pop          = !empty && (!valid_ff || !rsp_stall);
   assign updated      = (head.match_bit && (running_ff != '1)) ? running_ff + 1'b1 : running_ff;
   assign updated_wide = KEY_WIDTH'(updated);

   always_comb begin
      running_in = running_ff;
      valid_in   = valid_ff && rsp_stall;
      bit_in     = bit_ff;
      count_in   = count_ff;
      final_in   = final_ff;
      if (pop) begin
         // clear the total once the column's last row is answered
         running_in = head.last_row ? '0 : updated;
         valid_in   = 1'b1;
         bit_in     = head.match_bit;
         count_in   = updated_wide[MATCH_COUNT_WIDTH-1:0];
         final_in   = head.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         running_ff <= running_in;
         valid_ff   <= valid_in;
      end
      bit_ff   <= bit_in;
      count_ff <= count_in;
      final_ff <= final_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_match_bit   = bit_ff;
   assign rsp_match_count = count_ff;
   assign rsp_count_final = final_ff;

endmodule
